### design/afb_pkg.sv
// Shared types, register indexes, a saturation helper and a product helper for
// the affine rectangle bounding box block. No dependencies.
`default_nettype none

package afb_pkg;

  localparam int QW = 32;
  localparam int WW = 50;
  localparam int PW = 48;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef q_t [3:0] quad_t;

  typedef struct packed {
    q_t xx;
    q_t xy;
    q_t ox;
    q_t yx;
    q_t yy;
    q_t oy;
  } coef_t;

  typedef struct packed {
    q_t height;
    q_t width;
    q_t top;
    q_t left;
  } box_t;

  localparam logic [2:0] REG_COEF_XX  = 3'd0;
  localparam logic [2:0] REG_COEF_XY  = 3'd1;
  localparam logic [2:0] REG_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_COEF_YX  = 3'd3;
  localparam logic [2:0] REG_COEF_YY  = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;

  localparam q_t Q_ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  function automatic q_t sat_q(input wide_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WW-1:QW-1];
    hi_zeros = ~|v[WW-1:QW-1];
    if (hi_ones || hi_zeros) begin
      return v[QW-1:0];
    end else if (v[WW-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  // Full product, then drop 16 fraction bits (floor).
  function automatic prod_t mul_q(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    p = 64'(a) * 64'(b);
    return p[2*QW-1:16];
  endfunction

endpackage

`default_nettype wire

### design/afb_edges.sv
// Input register and corner edge stage: forms saturated right and bottom edges.
// Depends on afb_pkg.
`default_nettype none

module afb_edges
  import afb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire box_t in_rect,
  output logic      out_valid,
  input  wire logic out_ready,
  output q_t        left,
  output q_t        top,
  output q_t        right,
  output q_t        bottom
);

  logic v0;
  box_t rect0;
  logic ld0;
  logic ld1;

  assign ld1       = !out_valid || out_ready;
  assign ld0       = !v0 || ld1;
  assign in_ready  = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld0) begin
        v0 <= in_valid;
      end
      if (ld1) begin
        out_valid <= v0;
      end
    end
    if (ld0 && in_valid) begin
      rect0 <= in_rect;
    end
    if (ld1 && v0) begin
      left   <= rect0.left;
      top    <= rect0.top;
      right  <= sat_q(wide_t'(rect0.left) + wide_t'(rect0.width));
      bottom <= sat_q(wide_t'(rect0.top) + wide_t'(rect0.height));
    end
  end

endmodule

`default_nettype wire

### design/afb_map.sv
// Corner mapping: eight registered Q32.16 products, then saturated corner sums.
// Depends on afb_pkg.
`default_nettype none

module afb_map
  import afb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire coef_t coef,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire q_t    left,
  input  wire q_t    top,
  input  wire q_t    right,
  input  wire q_t    bottom,
  output logic       out_valid,
  input  wire logic  out_ready,
  output quad_t      cx,
  output quad_t      cy
);

  logic  vp;
  prod_t p_xl, p_xr, p_xt, p_xb;
  prod_t p_yl, p_yr, p_yt, p_yb;
  logic  ldp;
  logic  ldc;

  assign ldc      = !out_valid || out_ready;
  assign ldp      = !vp || ldc;
  assign in_ready = ldp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ldp) begin
        vp <= in_valid;
      end
      if (ldc) begin
        out_valid <= vp;
      end
    end
    if (ldp && in_valid) begin
      p_xl <= mul_q(coef.xx, left);
      p_xr <= mul_q(coef.xx, right);
      p_xt <= mul_q(coef.xy, top);
      p_xb <= mul_q(coef.xy, bottom);
      p_yl <= mul_q(coef.yx, left);
      p_yr <= mul_q(coef.yx, right);
      p_yt <= mul_q(coef.yy, top);
      p_yb <= mul_q(coef.yy, bottom);
    end
    if (ldc && vp) begin
      cx[0] <= sat_q(wide_t'(p_xl) + wide_t'(p_xt) + wide_t'(coef.ox));
      cx[1] <= sat_q(wide_t'(p_xl) + wide_t'(p_xb) + wide_t'(coef.ox));
      cx[2] <= sat_q(wide_t'(p_xr) + wide_t'(p_xt) + wide_t'(coef.ox));
      cx[3] <= sat_q(wide_t'(p_xr) + wide_t'(p_xb) + wide_t'(coef.ox));
      cy[0] <= sat_q(wide_t'(p_yl) + wide_t'(p_yt) + wide_t'(coef.oy));
      cy[1] <= sat_q(wide_t'(p_yl) + wide_t'(p_yb) + wide_t'(coef.oy));
      cy[2] <= sat_q(wide_t'(p_yr) + wide_t'(p_yt) + wide_t'(coef.oy));
      cy[3] <= sat_q(wide_t'(p_yr) + wide_t'(p_yb) + wide_t'(coef.oy));
    end
  end

endmodule

`default_nettype wire

### design/afb_box.sv
// Bounding box stage: registered min/max over four corners, then the output
// register with saturated extents. Depends on afb_pkg.
`default_nettype none

module afb_box
  import afb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire quad_t cx,
  input  wire quad_t cy,
  output logic       out_valid,
  input  wire logic  out_ready,
  output box_t       box
);

  logic vm;
  q_t   xmin, xmax, ymin, ymax;
  logic ldm;
  logic ldo;

  function automatic q_t min4(input quad_t c);
    q_t a;
    q_t b;
    a = (c[1] < c[0]) ? c[1] : c[0];
    b = (c[3] < c[2]) ? c[3] : c[2];
    return (b < a) ? b : a;
  endfunction

  function automatic q_t max4(input quad_t c);
    q_t a;
    q_t b;
    a = (c[1] > c[0]) ? c[1] : c[0];
    b = (c[3] > c[2]) ? c[3] : c[2];
    return (b > a) ? b : a;
  endfunction

  assign ldo      = !out_valid || out_ready;
  assign ldm      = !vm || ldo;
  assign in_ready = ldm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ldm) begin
        vm <= in_valid;
      end
      if (ldo) begin
        out_valid <= vm;
      end
    end
    if (ldm && in_valid) begin
      xmin <= min4(cx);
      xmax <= max4(cx);
      ymin <= min4(cy);
      ymax <= max4(cy);
    end
    if (ldo && vm) begin
      box.left   <= xmin;
      box.top    <= ymin;
      box.width  <= sat_q(wide_t'(xmax) - wide_t'(xmin));
      box.height <= sat_q(wide_t'(ymax) - wide_t'(ymin));
    end
  end

endmodule

`default_nettype wire

### design/affine_rect_bounding_box.sv
// Affine rectangle bounding box: maps the corners of a rectangle through a 2D
// affine matrix and returns the axis-aligned box around them.
// Depends on afb_pkg, afb_edges, afb_map and afb_box.
//
// Usage:
//   The slave stream carries one rectangle per item; the master stream returns
//   one box per item, in order. All values are signed Q16.16 and saturate to
//   32 bits. The six matrix registers are written through cfg_we, cfg_index and
//   cfg_data; the user must write them only while no item is in flight; the
//   block does not enforce it. Indexes six and seven are ignored. An item passes
//   six registers from the accepting edge to m_tvalid: input register, edge sums,
//   eight 32x32 multipliers, corner sums, min/max, output register. Throughput
//   is one item per cycle while m_tready is high. Each stage holds its item only
//   while the next one is full and stalled, so empty stages keep taking items
//   while a finished box waits; a full pipeline holds six items before s_tready
//   drops. Synchronous reset empties the pipeline and loads the identity matrix.
`default_nettype none

module affine_rect_bounding_box
  import afb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // rect_left, rect_top, rect_width, rect_height (32 bits each)
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // box_left, box_top, box_width, box_height (32 bits each)
  output logic [127:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  coef_t coef;
  box_t  rect_in;
  box_t  box_out;

  logic  e_valid, e_ready;
  q_t    e_left, e_top, e_right, e_bottom;
  logic  c_valid, c_ready;
  quad_t cx, cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.xx <= Q_ONE;
      coef.xy <= '0;
      coef.ox <= '0;
      coef.yx <= '0;
      coef.yy <= Q_ONE;
      coef.oy <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_XX:  coef.xx <= cfg_data;
        REG_COEF_XY:  coef.xy <= cfg_data;
        REG_OFFSET_X: coef.ox <= cfg_data;
        REG_COEF_YX:  coef.yx <= cfg_data;
        REG_COEF_YY:  coef.yy <= cfg_data;
        REG_OFFSET_Y: coef.oy <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign rect_in = s_tdata;
  assign m_tdata = box_out;

  afb_edges u_edges (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_rect   (rect_in),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .left      (e_left),
    .top       (e_top),
    .right     (e_right),
    .bottom    (e_bottom)
  );

  afb_map u_map (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .left      (e_left),
    .top       (e_top),
    .right     (e_right),
    .bottom    (e_bottom),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .cx        (cx),
    .cy        (cy)
  );

  afb_box u_box (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .cx        (cx),
    .cy        (cy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .box       (box_out)
  );

  a_width_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !box_out.width[QW-1])
    else $error("box width is negative");

  a_height_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !box_out.height[QW-1])
    else $error("box height is negative");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
